[rtl/core/bfep_pkg.sv]
`timescale 1ns / 1ps

package bfep_pkg;

    localparam int FIFO_DEPTH  = 256;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int PKT_BYTES   = 8;
    localparam int LANE_W      = $clog2(PKT_BYTES);
    localparam int LEN_W       = $clog2(PKT_BYTES + 1);
    localparam int BYTE_W      = 8;
    localparam int PKT_W       = PKT_BYTES * BYTE_W;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 72;
    localparam int OUT_TUSER_W = 3;

    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_EVENT = 1'b1;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

    typedef struct packed {
        logic clr;
        logic load;
    } t_pack_ctrl;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        ptr_next = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dist(input logic [PTR_W-1:0] from,
                                                  input logic [PTR_W-1:0] to);
        logic [PTR_W:0] sum;
        if (to >= from) begin
            sum = {1'b0, to} - {1'b0, from};
        end else begin
            sum = {1'b0, to} + (PTR_W + 1)'(FIFO_DEPTH) - {1'b0, from};
        end
        ptr_dist = sum[PTR_W-1:0];
    endfunction

endpackage

[rtl/core/bfep_ram.sv]
`timescale 1ns / 1ps

module bfep_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/bfep_pack.sv]
`timescale 1ns / 1ps

module bfep_pack
    import bfep_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_pack_ctrl        i_ctrl,
    input  logic [BYTE_W-1:0] i_byte,
    output logic [LEN_W-1:0]  o_len,
    output logic [PKT_W-1:0]  o_data
);

    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] n_len;
    logic [PKT_W-1:0] r_data;
    logic [PKT_W-1:0] n_data;

    always_comb begin
        n_len  = r_len;
        n_data = r_data;
        if (i_ctrl.clr) begin
            n_len  = '0;
            n_data = '0;
        end else if (i_ctrl.load) begin
            for (int i = 0; i < PKT_BYTES; i++) begin
                if (r_len[LANE_W-1:0] == LANE_W'(i)) begin
                    n_data[i*BYTE_W +: BYTE_W] = i_byte;
                end
            end
            n_len = r_len + LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_data <= '0;
        end else begin
            r_len  <= n_len;
            r_data <= n_data;
        end
    end

    assign o_len  = r_len;
    assign o_data = r_data;

endmodule

[rtl/core/byte_fifo_to_endpoint_packetizer_unit.sv]
`timescale 1ns / 1ps
// Transmit byte ring FIFO feeding an 8-byte bulk endpoint.
// Slave stream: one word per write-call byte or per transmit-complete event.
//   s_axis_tuser is the op (0 byte, 1 event), s_axis_tlast marks the call end,
//   s_axis_tdata carries the byte, the call-start mark and the all-or-nothing
//   mode. The register device_configured is set through i_cfg_we/i_cfg_wdata.
// Master stream: one result word per slave word, flags in m_axis_tuser,
//   packet length, 64-bit packet data and the sending flag in m_axis_tdata.
// Flow: an accepted word is registered and executed, and its result is then
//   loaded into the output register; a packet launch first reads the packet's
//   bytes in turn from the byte store, which has a single registered read port.
//   A new word is taken once the result of the previous one has moved into
//   the output register.
// Reset clears the pointers, the abort and sending flags and the register;
// the store itself is not cleared. When the receiver stalls, the result is
// held in the output register and the next word is processed; it then waits
// until the output register is free.

module byte_fifo_to_endpoint_packetizer_unit
    import bfep_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // data_byte, call_start, all_or_nothing
    input  logic                   s_axis_tlast,   // call_end
    input  logic                   s_axis_tuser,   // op
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // pkt_len, packet_data, sending
    output logic [OUT_TUSER_W-1:0] m_axis_tuser    // byte_accepted, byte_dropped, packet_valid
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LAUNCH,
        S_FINISH
    } t_state;

    t_state r_state, n_state;

    logic              r_cfg;
    logic              r_op, n_op;
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic              r_start, n_start;
    logic              r_end, n_end;
    logic              r_aon, n_aon;

    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [PTR_W-1:0] r_saved, n_saved;
    logic             r_aborted, n_aborted;
    logic             r_busy, n_busy;

    logic [LEN_W-1:0] r_cnt, n_cnt;
    logic             r_pend, n_pend;
    logic             r_acc, n_acc;
    logic             r_drop, n_drop;
    logic             r_pval, n_pval;

    logic                   r_m_valid, n_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_data, n_m_data;
    logic [OUT_TUSER_W-1:0] r_m_user, n_m_user;

    logic              ram_we;
    logic [BYTE_W-1:0] ram_rdata;
    t_pack_ctrl        pack_ctrl;
    logic [LEN_W-1:0]  pack_len;
    logic [PKT_W-1:0]  pack_data;

    logic             abort_eff;
    logic [PTR_W-1:0] saved_eff;
    logic [PTR_W-1:0] span;
    logic [PTR_W-1:0] rpos;
    logic             refuse;
    logic             issue;

    bfep_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(FIFO_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_wr),
        .i_wdata(r_byte),
        .i_raddr(r_rd),
        .o_rdata(ram_rdata)
    );

    bfep_pack u_pack (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctrl (pack_ctrl),
        .i_byte (ram_rdata),
        .o_len  (pack_len),
        .o_data (pack_data)
    );

    assign abort_eff = r_start ? 1'b0 : r_aborted;
    assign saved_eff = r_start ? r_wr : r_saved;
    assign span      = ptr_dist(saved_eff, r_wr);
    assign rpos      = ptr_dist(saved_eff, r_rd);
    assign refuse    = !r_cfg || (ptr_next(r_wr) == r_rd);
    assign issue     = (r_cnt != LEN_W'(PKT_BYTES)) && (r_rd != r_wr);

    assign s_axis_tready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_byte    = r_byte;
        n_start   = r_start;
        n_end     = r_end;
        n_aon     = r_aon;
        n_wr      = r_wr;
        n_rd      = r_rd;
        n_saved   = r_saved;
        n_aborted = r_aborted;
        n_busy    = r_busy;
        n_cnt     = r_cnt;
        n_pend    = r_pend;
        n_acc     = r_acc;
        n_drop    = r_drop;
        n_pval    = r_pval;
        n_m_valid = r_m_valid && !m_axis_tready;
        n_m_data  = r_m_data;
        n_m_user  = r_m_user;
        ram_we    = 1'b0;
        pack_ctrl = '0;

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op          = s_axis_tuser;
                    n_byte        = s_axis_tdata[BYTE_W-1:0];
                    n_start       = s_axis_tdata[BYTE_W];
                    n_aon         = s_axis_tdata[BYTE_W+1];
                    n_end         = s_axis_tlast;
                    n_acc         = 1'b0;
                    n_drop        = 1'b0;
                    n_pval        = 1'b0;
                    pack_ctrl.clr = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                n_cnt  = '0;
                n_pend = 1'b0;
                if (r_op == OP_EVENT) begin
                    if (r_rd == r_wr) begin
                        n_busy  = 1'b0;
                        n_rd    = '0;
                        n_wr    = '0;
                        n_saved = '0;
                        n_state = S_FINISH;
                    end else begin
                        n_pval  = 1'b1;
                        n_state = S_LAUNCH;
                    end
                end else begin
                    n_aborted = abort_eff;
                    n_saved   = saved_eff;
                    n_state   = S_FINISH;
                    if (abort_eff) begin
                        n_drop = 1'b1;
                    end else if (refuse) begin
                        n_drop    = 1'b1;
                        n_aborted = 1'b1;
                        if (r_aon) begin
                            n_wr = (rpos <= span) ? r_rd : saved_eff;
                        end
                    end else begin
                        ram_we = 1'b1;
                        n_wr   = ptr_next(r_wr);
                        n_acc  = 1'b1;
                        if (r_end && !r_busy) begin
                            n_pval  = 1'b1;
                            n_state = S_LAUNCH;
                        end
                    end
                end
            end
            S_LAUNCH: begin
                if (issue) begin
                    n_rd  = ptr_next(r_rd);
                    n_cnt = r_cnt + LEN_W'(1);
                end
                n_pend         = issue;
                pack_ctrl.load = r_pend;
                if (!issue && !r_pend) begin
                    n_busy  = 1'b1;
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_user  = {r_pval, r_drop, r_acc};
                    n_m_data  = OUT_TDATA_W'({r_busy, pack_data, pack_len});
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cfg     <= 1'b0;
            r_wr      <= '0;
            r_rd      <= '0;
            r_saved   <= '0;
            r_aborted <= 1'b0;
            r_busy    <= 1'b0;
            r_cnt     <= '0;
            r_pend    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            r_wr      <= n_wr;
            r_rd      <= n_rd;
            r_saved   <= n_saved;
            r_aborted <= n_aborted;
            r_busy    <= n_busy;
            r_cnt     <= n_cnt;
            r_pend    <= n_pend;
            r_m_valid <= n_m_valid;
        end
        r_op     <= n_op;
        r_byte   <= n_byte;
        r_start  <= n_start;
        r_end    <= n_end;
        r_aon    <= n_aon;
        r_acc    <= n_acc;
        r_drop   <= n_drop;
        r_pval   <= n_pval;
        r_m_data <= n_m_data;
        r_m_user <= n_m_user;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

endmodule
